@@ src/hsds_pkg.sv @@
// Package for the hashed string dedup set: capacity, hash constants, the
// sequencer state type and the command and status words of the slot table.
// No dependencies.
package hsds_pkg;

  localparam int SET_CAPACITY = 256;
  localparam int KEY_W        = 32;
  localparam int IDX_W        = $clog2(SET_CAPACITY);
  localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
  localparam int OUT_CNT_W    = 9;
  localparam int BIT_W        = $clog2(KEY_W);

  localparam logic [KEY_W-1:0] OFFSET_BASIS = 32'd2166136261;
  localparam logic [KEY_W-1:0] EMPTY_KEY    = 32'd0;
  localparam logic [KEY_W-1:0] ZERO_SUB_KEY = 32'd1;

  // A power-of-two capacity takes the start slot straight from the low hash bits.
  localparam bit CAP_POW2 = (SET_CAPACITY & (SET_CAPACITY - 1)) == 0;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [IDX_W:0]       idx_wide_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  localparam idx_wide_t CAP_WIDE = idx_wide_t'(SET_CAPACITY);
  localparam idx_t      LAST_IDX = idx_t'(SET_CAPACITY - 1);
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(KEY_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REDUCE,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic clear;
    logic rd;
    logic wr;
    idx_t addr;
    key_t key;
  } tbl_cmd_t;

  typedef struct packed {
    logic slot_used;
    logic key_match;
    cnt_t count;
  } tbl_stat_t;

endpackage

@@ src/hashed_string_dedup_set_top.sv @@
// Hashed string dedup set, top level.
// Instantiates hsds_hash, hsds_ctrl and hsds_table; uses hsds_pkg.
//
// Usage: strings arrive one byte per input word. A word is taken at a rising
// edge where start is high and busy is low. in_no_byte marks a word without a
// byte (to close an empty string), in_last_byte closes the string and starts
// the table probe, and in_new_set empties the set before the word is handled.
// Words that do not close a string leave busy low, so the next word can follow.
// A closing word raises busy: the hash is latched, a bit-serial reduction
// over all 32 hash bits gives the start slot when the capacity is not a
// power of two (none when it is), then each slot visited takes a registered
// memory read and then a compare. A full set with a new key visits every
// slot. The result word appears on the out_ ports for exactly one cycle,
// marked by out_valid, in the cycle after the last compare; busy is already
// low then. The receiver cannot stall.
// Reset clears the occupied bits and count at once and restores the hash
// offset basis; there is no clearing pass.
module hashed_string_dedup_set_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_text_byte,
  input  logic       in_no_byte,
  input  logic       in_last_byte,
  input  logic       in_new_set,
  output logic       out_valid,
  output logic       out_duplicate,
  output logic       out_stored,
  output logic [8:0] out_entry_count
);
  import hsds_pkg::*;

  logic      accept;
  key_t      hash_acc;
  logic      hash_restart;
  tbl_cmd_t  cmd;
  tbl_stat_t stat;

  assign accept = start && !busy;

  hsds_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept && !in_no_byte),
    .text_byte (in_text_byte),
    .restart   (hash_restart),
    .acc       (hash_acc)
  );

  hsds_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .begin_probe   (accept && in_last_byte),
    .clear_req     (accept && in_new_set),
    .hash_in       (hash_acc),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy),
    .hash_restart  (hash_restart),
    .res_valid     (out_valid),
    .res_duplicate (out_duplicate),
    .res_stored    (out_stored),
    .res_count     (out_entry_count)
  );

  hsds_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // A closing word always starts a probe.
  a_probe_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> busy)
    else $error("closing word did not start a probe");

  // Results come out only once the sequencer is idle again.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while probe still running");

  // A probe needs at least a read and a compare, so strobes never abut.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A key is never both found and inserted.
  a_dup_xor_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_duplicate && out_stored))
    else $error("result flags both duplicate and stored");

  // Table writes happen only during the compare step, never with a clear.
  a_no_wr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (!cmd.clear && busy))
    else $error("table write outside a probe");

endmodule

@@ src/hsds_hash.sv @@
// FNV-1a hash accumulator: folds in the byte of each accepted word that carries one.
// Uses hsds_pkg.
module hsds_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        text_byte,
  input  logic              restart,
  output hsds_pkg::key_t    acc
);
  import hsds_pkg::*;

  key_t acc_r;
  key_t acc_nxt;
  key_t mixed;

  // The prime 16777619 is 2^24 + 256 + 128 + 16 + 2 + 1, so the product is a shift-add.
  assign mixed = acc_r ^ {24'd0, text_byte};

  always_comb begin
    acc_nxt = acc_r;
    if (restart) begin
      acc_nxt = OFFSET_BASIS;
    end else if (step) begin
      acc_nxt = (mixed << 24) + (mixed << 8) + (mixed << 7) + (mixed << 4)
              + (mixed << 1) + mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= OFFSET_BASIS;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ src/hsds_table.sv @@
// Slot table: key memory with registered read, per-slot occupied bits,
// occupied count and the key compare.
// Uses hsds_pkg.
module hsds_table (
  input  logic                clk,
  input  logic                rst_n,
  input  hsds_pkg::tbl_cmd_t  cmd,
  output hsds_pkg::tbl_stat_t stat
);
  import hsds_pkg::*;

  key_t mem [SET_CAPACITY];
  key_t rd_key_r;

  logic [SET_CAPACITY-1:0] valid_r;
  logic [SET_CAPACITY-1:0] valid_nxt;
  cnt_t                    count_r;
  cnt_t                    count_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.key;
    end
    if (cmd.rd) begin
      rd_key_r <= mem[cmd.addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      valid_nxt = '0;
      count_nxt = '0;
    end else if (cmd.wr) begin
      valid_nxt[cmd.addr] = 1'b1;
      count_nxt = count_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.slot_used = valid_r[cmd.addr];
  assign stat.key_match = (rd_key_r == cmd.key);
  assign stat.count     = count_r;

endmodule

@@ src/hsds_ctrl.sv @@
// Probe sequencer: takes the finished hash, reduces it to a start slot, then
// walks the table one slot per read/check pair and forms the result word.
// Uses hsds_pkg; drives hsds_table through tbl_cmd_t.
module hsds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                begin_probe,
  input  logic                clear_req,
  input  hsds_pkg::key_t      hash_in,
  input  hsds_pkg::tbl_stat_t stat,
  output hsds_pkg::tbl_cmd_t  cmd,
  output logic                busy,
  output logic                hash_restart,
  output logic                res_valid,
  output logic                res_duplicate,
  output logic                res_stored,
  output hsds_pkg::out_cnt_t  res_count
);
  import hsds_pkg::*;

  state_t state_r, state_nxt;

  key_t             key_r, key_nxt;
  key_t             hash_r, hash_nxt;
  idx_t             pos_r, pos_nxt;
  idx_t             steps_r, steps_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;

  logic     valid_r, valid_nxt;
  logic     dup_r, dup_nxt;
  logic     stored_r, stored_nxt;
  out_cnt_t cnt_r, cnt_nxt;

  idx_wide_t trial;
  logic      probe_end;

  // One step of restoring reduction: shift in the next hash bit, subtract once.
  assign trial = {pos_r, hash_r[bit_r]};

  assign probe_end = !stat.slot_used || stat.key_match || (steps_r == LAST_IDX);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (begin_probe) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = CAP_POW2 ? ST_READ : ST_REDUCE;
      ST_REDUCE: if (bit_r == '0) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = probe_end ? ST_IDLE : ST_READ;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs toward the hash unit and the table.
  always_comb begin
    busy         = (state_r != ST_IDLE);
    hash_restart = (state_r == ST_LOAD);
    cmd.clear    = clear_req;
    cmd.rd       = (state_r == ST_READ);
    cmd.wr       = (state_r == ST_CHECK) && !stat.slot_used;
    cmd.addr     = pos_r;
    cmd.key      = key_r;
  end

  // Datapath registers.
  always_comb begin
    key_nxt    = key_r;
    hash_nxt   = hash_r;
    pos_nxt    = pos_r;
    steps_nxt  = steps_r;
    bit_nxt    = bit_r;
    valid_nxt  = 1'b0;
    dup_nxt    = dup_r;
    stored_nxt = stored_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      ST_LOAD: begin
        // A zero hash is kept as one; empty slots are marked by the occupied bits, not by zero.
        key_nxt   = (hash_in == EMPTY_KEY) ? ZERO_SUB_KEY : hash_in;
        hash_nxt  = hash_in;
        pos_nxt   = CAP_POW2 ? hash_in[IDX_W-1:0] : '0;
        steps_nxt = '0;
        bit_nxt   = TOP_BIT;
      end
      ST_REDUCE: begin
        pos_nxt = (trial >= CAP_WIDE) ? idx_t'(trial - CAP_WIDE) : idx_t'(trial);
        bit_nxt = bit_r - 1'b1;
      end
      ST_CHECK: begin
        if (probe_end) begin
          valid_nxt  = 1'b1;
          dup_nxt    = stat.slot_used && stat.key_match;
          stored_nxt = !stat.slot_used;
          cnt_nxt    = stat.slot_used ? out_cnt_t'(stat.count)
                                      : out_cnt_t'(stat.count + cnt_t'(1));
        end else begin
          pos_nxt   = (pos_r == LAST_IDX) ? '0 : pos_r + idx_t'(1);
          steps_nxt = steps_r + idx_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    hash_r   <= hash_nxt;
    pos_r    <= pos_nxt;
    steps_r  <= steps_nxt;
    bit_r    <= bit_nxt;
    dup_r    <= dup_nxt;
    stored_r <= stored_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign res_valid     = valid_r;
  assign res_duplicate = dup_r;
  assign res_stored    = stored_r;
  assign res_count     = cnt_r;

endmodule
